>>> design/lcdi_pkg.sv
package lcdi_pkg;

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_CMD   = 3'd1,
        PH_ARGC  = 3'd2,
        PH_ARG   = 3'd3,
        PH_DELAY = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_DELAY  = 2'd3
    } kind_t;

    localparam int DELAY_FLAG_BIT = 7;
    localparam logic [7:0] DELAY_LONG    = 8'd255;
    localparam logic [8:0] DELAY_LONG_MS = 9'd500;

    localparam int TDATA_W = 24;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] commands_left;
        logic [6:0] args_left;
        logic       delay_follows;
    } lcdi_state_t;

    typedef struct packed {
        kind_t      item_kind;
        logic [7:0] out_byte;
        logic [8:0] delay_ms;
        logic       list_done;
    } lcdi_result_t;

endpackage

>>> design/lcdi_decode.sv
module lcdi_decode
    import lcdi_pkg::*;
(
    input  lcdi_state_t  state,
    input  logic [7:0]   list_byte,
    output lcdi_state_t  state_next,
    output lcdi_result_t result
);

    logic [6:0] args_dec;
    logic       last_cmd;

    assign args_dec = state.args_left - 7'd1;
    assign last_cmd = (state.commands_left == 8'd0);

    // next state
    always_comb
    begin
        state_next = state;
        case (state.phase)
            PH_CMD:
            begin
                state_next.commands_left = state.commands_left - 8'd1;
                state_next.phase         = PH_ARGC;
            end
            PH_ARGC:
            begin
                state_next.args_left     = list_byte[6:0];
                state_next.delay_follows = list_byte[DELAY_FLAG_BIT];
                if (list_byte[6:0] != 7'd0)
                    state_next.phase = PH_ARG;
                else if (list_byte[DELAY_FLAG_BIT])
                    state_next.phase = PH_DELAY;
                else
                    state_next.phase = last_cmd ? PH_COUNT : PH_CMD;
            end
            PH_ARG:
            begin
                state_next.args_left = args_dec;
                if (args_dec == 7'd0)
                begin
                    if (state.delay_follows)
                        state_next.phase = PH_DELAY;
                    else
                        state_next.phase = last_cmd ? PH_COUNT : PH_CMD;
                end
            end
            PH_DELAY:
            begin
                state_next.delay_follows = 1'b0;
                state_next.phase         = last_cmd ? PH_COUNT : PH_CMD;
            end
            default:
            begin
                state_next.commands_left = list_byte;
                state_next.args_left     = 7'd0;
                state_next.delay_follows = 1'b0;
                state_next.phase         = (list_byte == 8'd0) ? PH_COUNT : PH_CMD;
            end
        endcase
    end

    // result word for this byte
    always_comb
    begin
        result.item_kind = KIND_HEADER;
        result.out_byte  = 8'd0;
        result.delay_ms  = 9'd0;
        result.list_done = 1'b0;
        case (state.phase)
            PH_CMD:
            begin
                result.item_kind = KIND_CMD;
                result.out_byte  = list_byte;
            end
            PH_ARGC:
            begin
                result.list_done = (list_byte[6:0] == 7'd0) && !list_byte[DELAY_FLAG_BIT]
                                   && last_cmd;
            end
            PH_ARG:
            begin
                result.item_kind = KIND_DATA;
                result.out_byte  = list_byte;
                result.list_done = (args_dec == 7'd0) && !state.delay_follows && last_cmd;
            end
            PH_DELAY:
            begin
                result.item_kind = KIND_DELAY;
                result.delay_ms  = (list_byte == DELAY_LONG) ? DELAY_LONG_MS
                                                             : {1'b0, list_byte};
                result.list_done = last_cmd;
            end
            default:
            begin
                // empty list ends on its own count byte
                result.list_done = (list_byte == 8'd0);
            end
        endcase
    end

endmodule

>>> design/lcdi_out_stage.sv
module lcdi_out_stage
    import lcdi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  lcdi_result_t result,
    output logic         ready,
    output logic         valid,
    input  logic         take,
    output lcdi_result_t held
);

    logic         valid_reg;
    logic         valid_next;
    lcdi_result_t result_reg;

    // the register frees up in the same cycle its word is taken
    assign ready      = !valid_reg || take;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign valid = valid_reg;
    assign held  = result_reg;

endmodule

>>> design/lcd_init_command_list_interpreter.sv
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | tdata[7:0] list_byte
// m_*      | out | m_tvalid/m_tready  | tdata out_byte, delay_ms; tuser item_kind; tlast list_done
//
// One word in, one word out, one word per cycle sustained while the output is not stalled.
// The result word appears in the cycle after its byte is accepted: the list walker
// state and the result register both load on the accepting edge.
// Reset clears the walker to expect a count byte and empties the result register.
// A stalled output holds its word; input is taken again in the cycle that word leaves.
module lcd_init_command_list_interpreter
    import lcdi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] list_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [16:8] delay_ms, [23:17] zero
    output logic [1:0]         m_tuser,   // [1:0] item_kind
    output logic               m_tlast    // list_done
);

    lcdi_state_t  state_reg;
    lcdi_state_t  state_next;
    lcdi_result_t result;
    lcdi_result_t held;
    logic         accept;
    logic         take;

    assign accept = s_tvalid && s_tready;
    assign take   = m_tvalid && m_tready;

    lcdi_decode u_decode (
        .state      (state_reg),
        .list_byte  (s_tdata),
        .state_next (state_next),
        .result     (result)
    );

    lcdi_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .result (result),
        .ready  (s_tready),
        .valid  (m_tvalid),
        .take   (take),
        .held   (held)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_COUNT;
            state_reg.commands_left <= 8'd0;
            state_reg.args_left     <= 7'd0;
            state_reg.delay_follows <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    assign m_tdata = {7'd0, held.delay_ms, held.out_byte};
    assign m_tuser = held.item_kind;
    assign m_tlast = held.list_done;

    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted byte produced no result word");

    a_cmd_then_argc: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (state_reg.phase == PH_CMD) |=> state_reg.phase == PH_ARGC)
        else $error("command byte not followed by argument count");

    a_header_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_HEADER) |-> m_tdata == '0)
        else $error("header word carries payload");

    a_delay_only_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_DELAY) |-> m_tdata[16:8] == 9'd0)
        else $error("delay value on a non-delay word");

endmodule
